// File: rtl/gwp_pkg.sv
// Package: shared fixed-point constants for the win probability unit.
`default_nettype none
package gwp_pkg;
   localparam int IB = 28;
   localparam logic [63:0] IONE       = 64'd1 << IB;
   localparam logic [31:0] INV_SQRT2_Q = 32'd189812531;
   localparam logic [31:0] A_Q        = 32'd37584263;
   localparam logic [31:0] FOUR_PI_Q  = 32'd341782638;
   localparam logic [31:0] LOG2E_Q    = 32'd387270501;
   localparam logic [31:0] LN2_Q      = 32'd186065280;
   localparam logic [63:0] Z_MAX      = 64'd8 << IB;
   localparam logic [63:0] T_MAX      = 64'd20 << IB;
   localparam int TAYLOR_TERMS = 14;
endpackage
`default_nettype wire

// File: rtl/gwp_if.sv
// Interface: valid/ready channel carrying a generic payload.
`default_nettype none
interface gwp_if #(parameter int W = 8) (input wire logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/gwp_div.sv
// Pipelined restoring divider: one quotient bit per stage.
`default_nettype none
module gwp_div #(
   parameter int NW = 64,
   parameter int DW = 34,
   parameter int TW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_num,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [TW-1:0] in_tag,
   output      logic          out_valid,
   output      logic [NW-1:0] out_quo,
   output      logic [TW-1:0] out_tag
);
   logic          v  [0:NW];
   logic [NW-1:0] q  [0:NW];
   logic [DW-1:0] r  [0:NW];
   logic [DW-1:0] d  [0:NW];
   logic [TW-1:0] tg [0:NW];
   assign v[0] = in_valid;
   assign q[0] = in_num;
   assign r[0] = '0;
   assign d[0] = in_den;
   assign tg[0] = in_tag;
   genvar i;
   for (i = 0; i < NW; i++) begin : g_st
      logic [DW:0]   sh;
      logic [DW+1:0] df;
      logic          v_ff;
      logic [NW-1:0] q_ff;
      logic [DW-1:0] r_ff;
      logic [DW-1:0] d_ff;
      logic [TW-1:0] tg_ff;
      always_comb begin
         sh = {r[i], q[i][NW-1]};
         df = {1'b0, sh} - {2'b00, d[i]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v[i];
         end
         if (adv) begin
            r_ff  <= df[DW+1] ? sh[DW-1:0] : df[DW-1:0];
            q_ff  <= {q[i][NW-2:0], ~df[DW+1]};
            d_ff  <= d[i];
            tg_ff <= tg[i];
         end
      end
      assign v[i+1] = v_ff;
      assign q[i+1] = q_ff;
      assign r[i+1] = r_ff;
      assign d[i+1] = d_ff;
      assign tg[i+1] = tg_ff;
   end
   assign out_valid = v[NW];
   assign out_quo   = q[NW];
   assign out_tag   = tg[NW];
endmodule
`default_nettype wire

// File: rtl/gwp_sqrt.sv
// Pipelined integer square root: one result bit per stage.
`default_nettype none
module gwp_sqrt #(
   parameter int TW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_valid,
   input  wire logic [63:0]   in_val,
   input  wire logic [TW-1:0] in_tag,
   output      logic          out_valid,
   output      logic [31:0]   out_root,
   output      logic [TW-1:0] out_tag
);
   logic          v  [0:32];
   logic [63:0]   x  [0:32];
   logic [33:0]   rm [0:32];
   logic [31:0]   rt [0:32];
   logic [TW-1:0] tg [0:32];
   assign v[0] = in_valid;
   assign x[0] = in_val;
   assign rm[0] = '0;
   assign rt[0] = '0;
   assign tg[0] = in_tag;
   genvar i;
   for (i = 0; i < 32; i++) begin : g_st
      logic [33:0] tr, trial;
      logic [34:0] df;
      logic        v_ff;
      logic [63:0] x_ff;
      logic [33:0] rm_ff;
      logic [31:0] rt_ff;
      logic [TW-1:0] tg_ff;
      always_comb begin
         tr = {rm[i][31:0], x[i][63:62]};
         trial = {rt[i], 2'b01};
         df = {1'b0, tr} - {1'b0, trial};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v[i];
         end
         if (adv) begin
            x_ff  <= {x[i][61:0], 2'b00};
            rm_ff <= df[34] ? tr : df[33:0];
            rt_ff <= {rt[i][30:0], ~df[34]};
            tg_ff <= tg[i];
         end
      end
      assign v[i+1] = v_ff;
      assign x[i+1] = x_ff;
      assign rm[i+1] = rm_ff;
      assign rt[i+1] = rt_ff;
      assign tg[i+1] = tg_ff;
   end
   assign out_valid = v[32];
   assign out_root = rt[32];
   assign out_tag = tg[32];
endmodule
`default_nettype wire

// File: rtl/gaussian_win_probability_unit.sv
// Pipeline: three 64-stage dividers, a 28-stage exp Taylor chain, a 32-stage
// root, plus eight single stages and the output register.
// Throughput: one transaction per cycle; the whole pipeline advances when the
// output register is empty or taken, so a stall freezes every stage.
// Reset: synchronous, active high; clears all stage valid bits.
`default_nettype none
module gaussian_win_probability_unit import gwp_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   gwp_if.sink   req,
   gwp_if.source rsp
);
   localparam int MW = FRAC_BITS + 1;
   localparam int SH = IB + 1 - FRAC_BITS;
   localparam int TW = 3; // neg, zero-difference, degenerate

   logic adv;
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   logic [MW-1:0] m1, m2;
   logic [FRAC_BITS-1:0] s1, s2;
   assign m1 = req.data[MW-1:0];
   assign s1 = req.data[MW+FRAC_BITS-1:MW];
   assign m2 = req.data[2*MW+FRAC_BITS-1:MW+FRAC_BITS];
   assign s2 = req.data[2*MW+2*FRAC_BITS-1:2*MW+FRAC_BITS];

   // stage 0: difference and deviation sum
   logic v0_ff;
   logic [MW-1:0] d0_ff;
   logic [FRAC_BITS:0] s0_ff;
   logic [TW-1:0] t0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req.valid;
      if (adv) begin
         d0_ff <= (m1 < m2) ? m2 - m1 : m1 - m2;
         s0_ff <= {1'b0, s1} + {1'b0, s2};
         t0_ff <= {({1'b0, s1} + {1'b0, s2}) == '0, m1 == m2, m1 < m2};
      end
   end

   // stage 1: numerator product
   logic v1_ff;
   logic [63:0] n1_ff;
   logic [FRAC_BITS:0] s1_ff;
   logic [TW-1:0] t1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= v0_ff;
      if (adv) begin
         n1_ff <= 64'(d0_ff) * 64'(INV_SQRT2_Q);
         s1_ff <= s0_ff;
         t1_ff <= t0_ff;
      end
   end

   logic vz;
   logic [63:0] zq;
   logic [TW-1:0] tz;
   gwp_div #(.NW(64), .DW(FRAC_BITS + 1), .TW(TW)) u_zdiv (
      .clock, .reset, .adv,
      .in_valid(v1_ff), .in_num(n1_ff),
      .in_den(t1_ff[2] ? {{FRAC_BITS{1'b0}}, 1'b1} : s1_ff), .in_tag(t1_ff),
      .out_valid(vz), .out_quo(zq), .out_tag(tz)
   );

   // stage: saturate, square
   logic v2_ff;
   logic [34:0] z2a_ff;
   logic [TW-1:0] t2_ff;
   logic [31:0] zs;
   assign zs = (zq > Z_MAX) ? Z_MAX[31:0] : zq[31:0];
   logic [63:0] zsq;
   assign zsq = 64'(zs) * 64'(zs);
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= vz;
      if (adv) begin
         z2a_ff <= zsq[IB+34:IB];
         t2_ff <= tz;
      end
   end

   logic v3_ff;
   logic [34:0] z2b_ff;
   logic [31:0] az_ff;
   logic [TW-1:0] t3_ff;
   logic [63:0] azp;
   assign azp = 64'(A_Q) * 64'(z2a_ff);
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         z2b_ff <= z2a_ff;
         az_ff <= azp[IB+31:IB];
         t3_ff <= t2_ff;
      end
   end

   logic vr;
   logic [63:0] rq;
   logic [34+TW:0] rtag;
   gwp_div #(.NW(64), .DW(34), .TW(35 + TW)) u_rdiv (
      .clock, .reset, .adv,
      .in_valid(v3_ff),
      .in_num((64'(FOUR_PI_Q) + 64'(az_ff)) << IB),
      .in_den(34'(IONE) + 34'(az_ff)),
      .in_tag({z2b_ff, t3_ff}),
      .out_valid(vr), .out_quo(rq), .out_tag(rtag)
   );

   // t = z2 * ratio
   logic v4_ff;
   logic [63:0] tp_ff;
   logic [TW-1:0] t4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= vr;
      if (adv) begin
         tp_ff <= 64'(rtag[34+TW:TW]) * 64'(rq[31:0]);
         t4_ff <= rtag[TW-1:0];
      end
   end
   logic [35:0] tv;
   assign tv = tp_ff[IB+35:IB];

   logic v5_ff, big5_ff;
   logic [63:0] up_ff;
   logic [TW-1:0] t5_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         big5_ff <= 64'(tv) >= T_MAX;
         up_ff <= 64'(tv) * 64'(LOG2E_Q);
         t5_ff <= t4_ff;
      end
   end
   logic [35:0] uv;
   assign uv = up_ff[IB+35:IB];

   logic v6_ff, big6_ff;
   logic [63:0] gp_ff;
   logic [7:0] n6_ff;
   logic [TW-1:0] t6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
      if (adv) begin
         big6_ff <= big5_ff;
         gp_ff <= 64'(uv[IB-1:0]) * 64'(LN2_Q);
         n6_ff <= uv[IB+7:IB];
         t6_ff <= t5_ff;
      end
   end

   // Taylor chain: product stage then divide-by-k stage per term
   localparam int NT = TAYLOR_TERMS;
   logic          tv_v   [0:NT];
   logic [31:0]   tv_g   [0:NT];
   logic [31:0]   tv_trm [0:NT];
   logic [31:0]   tv_sum [0:NT];
   logic [7:0]    tv_n   [0:NT];
   logic          tv_b   [0:NT];
   logic [TW-1:0] tv_t   [0:NT];
   assign tv_v[0] = v6_ff;
   assign tv_g[0] = gp_ff[IB+31:IB];
   assign tv_trm[0] = IONE[31:0];
   assign tv_sum[0] = IONE[31:0];
   assign tv_n[0] = n6_ff;
   assign tv_b[0] = big6_ff;
   assign tv_t[0] = t6_ff;
   genvar k;
   for (k = 1; k <= NT; k++) begin : g_tay
      // exact reciprocal for a 32-bit dividend
      localparam int KL = $clog2(k);
      localparam logic [32:0] KM = 33'(((64'd1 << (32 + KL)) / 64'(k)) + 64'd1);
      logic pv_ff, qv_ff, pb_ff, qb_ff;
      logic [63:0] pp_ff;
      logic [31:0] pg_ff, ps_ff, qg_ff, qt_ff, qs_ff;
      logic [7:0] pn_ff, qn_ff;
      logic [TW-1:0] pt_ff, qtg_ff;
      logic [71:0] qm;
      logic [31:0] qd;
      assign qm = 72'(pp_ff[IB+31:IB]) * 72'(KM);
      assign qd = qm[32+KL+31:32+KL];
      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff <= 1'b0;
            qv_ff <= 1'b0;
         end else if (adv) begin
            pv_ff <= tv_v[k-1];
            qv_ff <= pv_ff;
         end
         if (adv) begin
            pp_ff <= 64'(tv_trm[k-1]) * 64'(tv_g[k-1]);
            pg_ff <= tv_g[k-1];
            ps_ff <= tv_sum[k-1];
            pn_ff <= tv_n[k-1];
            pb_ff <= tv_b[k-1];
            pt_ff <= tv_t[k-1];
            qt_ff <= qd;
            qs_ff <= ps_ff + qd;
            qg_ff <= pg_ff;
            qn_ff <= pn_ff;
            qb_ff <= pb_ff;
            qtg_ff <= pt_ff;
         end
      end
      assign tv_v[k] = qv_ff;
      assign tv_g[k] = qg_ff;
      assign tv_trm[k] = qt_ff;
      assign tv_sum[k] = qs_ff;
      assign tv_n[k] = qn_ff;
      assign tv_b[k] = qb_ff;
      assign tv_t[k] = qtg_ff;
   end

   logic ve;
   logic [63:0] eq;
   logic [8+TW:0] etag;
   gwp_div #(.NW(64), .DW(34), .TW(9 + TW)) u_ediv (
      .clock, .reset, .adv,
      .in_valid(tv_v[NT]),
      .in_num((IONE << IB) + 64'(tv_sum[NT][31:1])),
      .in_den(34'(tv_sum[NT])),
      .in_tag({tv_b[NT], tv_n[NT], tv_t[NT]}),
      .out_valid(ve), .out_quo(eq), .out_tag(etag)
   );

   logic v7_ff;
   logic [63:0] sq_ff;
   logic [TW-1:0] t7_ff;
   logic [63:0] ex;
   logic [7:0] en;
   assign en = etag[7+TW:TW];
   always_comb begin
      if (etag[8+TW] || en >= 8'd63) ex = '0;
      else ex = eq >> en[5:0];
      if (ex > IONE) ex = IONE;
   end
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= ve;
      if (adv) begin
         sq_ff <= (IONE - ex) << IB;
         t7_ff <= etag[TW-1:0];
      end
   end

   logic vs;
   logic [31:0] root;
   logic [TW-1:0] ts;
   gwp_sqrt #(.TW(TW)) u_sqrt (
      .clock, .reset, .adv,
      .in_valid(v7_ff), .in_val(sq_ff), .in_tag(t7_ff),
      .out_valid(vs), .out_root(root), .out_tag(ts)
   );

   logic [31:0] em;
   logic [31:0] p2;
   logic [MW-1:0] prob, pn;
   assign em = (root > IONE[31:0]) ? IONE[31:0] : root;
   assign p2 = ts[0] ? IONE[31:0] - em : IONE[31:0] + em;
   always_comb begin
      if (SH > 0) pn = MW'((64'(p2) + (64'd1 << (SH - 1))) >> SH);
      else pn = MW'(64'(p2) << (-SH));
      if (ts[2]) begin
         if (ts[1]) prob = MW'(64'd1 << (FRAC_BITS - 1));
         else if (ts[0]) prob = '0;
         else prob = MW'(64'd1 << FRAC_BITS);
      end else begin
         prob = pn;
      end
   end

   logic [MW:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= vs;
      if (adv) rsp_data_ff <= {ts[2], prob};
   end
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;
endmodule
`default_nettype wire
